/* rtl/tlr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared constants and types for the thick line rasterizer.
// ----------------------------------------------------------------------------
package tlr_pkg;

  // Default widths handed to the top level
  localparam int COORD_BITS_DEF = 12;
  localparam int THICK_BITS_DEF = 5;

  // Fixed field widths
  localparam int FRAME_W = 12;
  localparam int PIX_W   = 11;
  localparam int COLOR_W = 24;

  // Largest usable frame size: pixel coordinates are PIX_W bits
  localparam logic [FRAME_W-1:0] PIX_LIMIT = FRAME_W'(2048);

  // Frame size after reset
  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = FRAME_W'(1024);
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = FRAME_W'(768);

  // Input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Status of one step of the brush walk
  typedef struct packed {
    logic in_frame; // pixel lies in the frame
    logic done;     // last offset of the end point
    logic wrap_j;   // inner offset wraps
    logic wrap_i;   // outer offset wraps, point moves or line ends
  } step_ctl_t;

endpackage

/* rtl/thick_line_rasterizer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thick_line_rasterizer_core
// Bresenham line walk with a square brush, one pixel write per tick.
// ----------------------------------------------------------------------------
// A tick transaction shows its pixel write in the cycle after acceptance.
// Throughput: one transaction per cycle while in_ready is high; the walk state
//   and the output register both update in the accepting cycle, one brush
//   offset per step. Starts give no result. Ticks while idle give no result.
// Reset (rst_n low, synchronous) clears busy, the offset counters and the
//   output valid, and sets the frame to 1024 x 768.
// ----------------------------------------------------------------------------
module thick_line_rasterizer_core #(
  parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
  parameter int THICK_BITS = tlr_pkg::THICK_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tlr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tlr_pkg::FRAME_W-1:0]         cfg_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic signed [COORD_BITS-1:0]        in_start_x,
  input  logic signed [COORD_BITS-1:0]        in_start_y,
  input  logic signed [COORD_BITS-1:0]        in_end_x,
  input  logic signed [COORD_BITS-1:0]        in_end_y,
  input  logic [tlr_pkg::COLOR_W-1:0]         in_color_rgb,
  input  logic [THICK_BITS-1:0]               in_thickness,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_write_enable,
  output logic [tlr_pkg::PIX_W-1:0]           out_pixel_x,
  output logic [tlr_pkg::PIX_W-1:0]           out_pixel_y,
  output logic [tlr_pkg::COLOR_W-1:0]         out_pixel_color,
  output logic                                out_line_done
);
  import tlr_pkg::*;

  localparam int ERR_W = COORD_BITS + 3;

  // configuration registers
  logic [FRAME_W-1:0] frame_width_r, frame_height_r;

  // walk state
  logic                         busy_r;
  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic        [COORD_BITS-1:0] delta_x_r, delta_y_r;
  logic                         step_x_neg_r, step_y_neg_r;
  logic signed [ERR_W-1:0]      error_r;
  logic        [THICK_BITS-1:0] half_r, offset_i_r, offset_j_r;
  logic        [COLOR_W-1:0]    color_r;

  // output register
  logic               out_valid_r;
  logic               out_we_r, out_done_r;
  logic [PIX_W-1:0]   out_x_r, out_y_r;
  logic [COLOR_W-1:0] out_color_r;

  // setup results
  logic        [COORD_BITS-1:0] su_dx, su_dy;
  logic                         su_sx_neg, su_sy_neg;
  logic signed [ERR_W-1:0]      su_err;
  logic        [THICK_BITS-1:0] su_half;

  // step results
  logic [PIX_W-1:0]             st_x, st_y;
  step_ctl_t                    st_ctl;
  logic signed [COORD_BITS-1:0] cur_x_nxt, cur_y_nxt;
  logic signed [ERR_W-1:0]      error_nxt;
  logic        [THICK_BITS-1:0] offset_i_nxt, offset_j_nxt;

  logic accept, take_start, take_tick;

  assign cfg_ready  = 1'b1;
  assign in_ready   = !out_valid_r || out_ready;
  assign accept     = in_valid && in_ready;
  assign take_start = accept && (in_action == ACT_START);
  assign take_tick  = accept && (in_action == ACT_TICK) && busy_r;

  tlr_setup #(
    .COORD_BITS (COORD_BITS),
    .THICK_BITS (THICK_BITS),
    .ERR_W      (ERR_W)
  ) u_setup (
    .start_x    (in_start_x),
    .start_y    (in_start_y),
    .end_x      (in_end_x),
    .end_y      (in_end_y),
    .thickness  (in_thickness),
    .delta_x    (su_dx),
    .delta_y    (su_dy),
    .step_x_neg (su_sx_neg),
    .step_y_neg (su_sy_neg),
    .error_init (su_err),
    .half_size  (su_half)
  );

  tlr_step #(
    .COORD_BITS (COORD_BITS),
    .THICK_BITS (THICK_BITS),
    .ERR_W      (ERR_W)
  ) u_step (
    .cur_x        (cur_x_r),
    .cur_y        (cur_y_r),
    .goal_x       (goal_x_r),
    .goal_y       (goal_y_r),
    .delta_x      (delta_x_r),
    .delta_y      (delta_y_r),
    .step_x_neg   (step_x_neg_r),
    .step_y_neg   (step_y_neg_r),
    .error_term   (error_r),
    .half_size    (half_r),
    .offset_i     (offset_i_r),
    .offset_j     (offset_j_r),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .pixel_x      (st_x),
    .pixel_y      (st_y),
    .ctl          (st_ctl),
    .cur_x_nxt    (cur_x_nxt),
    .cur_y_nxt    (cur_y_nxt),
    .error_nxt    (error_nxt),
    .offset_i_nxt (offset_i_nxt),
    .offset_j_nxt (offset_j_nxt)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      offset_i_r <= '0;
      offset_j_r <= '0;
    end else if (take_start) begin
      busy_r     <= 1'b1;
      offset_i_r <= '0;
      offset_j_r <= '0;
    end else if (take_tick) begin
      busy_r     <= !st_ctl.done;
      offset_i_r <= offset_i_nxt;
      offset_j_r <= offset_j_nxt;
    end
  end

  // Walk payload
  always_ff @(posedge clk) begin
    if (take_start) begin
      cur_x_r      <= in_start_x;
      cur_y_r      <= in_start_y;
      goal_x_r     <= in_end_x;
      goal_y_r     <= in_end_y;
      delta_x_r    <= su_dx;
      delta_y_r    <= su_dy;
      step_x_neg_r <= su_sx_neg;
      step_y_neg_r <= su_sy_neg;
      error_r      <= su_err;
      half_r       <= su_half;
      color_r      <= in_color_rgb;
    end else if (take_tick) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      error_r <= error_nxt;
    end
  end

  // Output register: load on a busy tick, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take_tick) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_tick) begin
      out_we_r    <= st_ctl.in_frame;
      out_x_r     <= st_ctl.in_frame ? st_x : '0;
      out_y_r     <= st_ctl.in_frame ? st_y : '0;
      out_color_r <= st_ctl.in_frame ? color_r : '0;
      out_done_r  <= st_ctl.done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_pixel_x      = out_x_r;
  assign out_pixel_y      = out_y_r;
  assign out_pixel_color  = out_color_r;
  assign out_line_done    = out_done_r;

  // A new result only follows a tick accepted while a line was running
  a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(take_tick))
    else $error("result appeared without a busy tick");

  // Offset counters never pass the square side
  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (offset_i_r <= (half_r << 1)) && (offset_j_r <= (half_r << 1)))
    else $error("brush offset out of range");

  // A finished line leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take_tick && st_ctl.done && !take_start |=> !busy_r)
    else $error("line done but still busy");

  // Clipped writes carry zero payload
  a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_we_r |-> (out_x_r == '0) && (out_y_r == '0) && (out_color_r == '0))
    else $error("clipped write with nonzero payload");

endmodule

/* rtl/tlr_setup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlr_setup
// Decodes a start transaction into the Bresenham walk parameters.
// ----------------------------------------------------------------------------
module tlr_setup #(
  parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
  parameter int THICK_BITS = tlr_pkg::THICK_BITS_DEF,
  parameter int ERR_W      = COORD_BITS + 3
) (
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic        [THICK_BITS-1:0] thickness,
  output logic        [COORD_BITS-1:0] delta_x,
  output logic        [COORD_BITS-1:0] delta_y,
  output logic                         step_x_neg,
  output logic                         step_y_neg,
  output logic signed [ERR_W-1:0]      error_init,
  output logic        [THICK_BITS-1:0] half_size
);
  import tlr_pkg::*;

  logic signed [COORD_BITS:0] diff_x;
  logic signed [COORD_BITS:0] diff_y;
  logic [ERR_W-1:0]           half_dx;
  logic [ERR_W-1:0]           half_dy;

  always_comb begin
    if (end_x > start_x) begin
      diff_x = (COORD_BITS+1)'(end_x) - (COORD_BITS+1)'(start_x);
    end else begin
      diff_x = (COORD_BITS+1)'(start_x) - (COORD_BITS+1)'(end_x);
    end
    if (end_y > start_y) begin
      diff_y = (COORD_BITS+1)'(end_y) - (COORD_BITS+1)'(start_y);
    end else begin
      diff_y = (COORD_BITS+1)'(start_y) - (COORD_BITS+1)'(end_y);
    end
  end

  assign delta_x    = diff_x[COORD_BITS-1:0];
  assign delta_y    = diff_y[COORD_BITS-1:0];
  assign step_x_neg = !(start_x < end_x);
  assign step_y_neg = !(start_y < end_y);

  // Halve toward zero: dx/2 when delta_x > delta_y, else -(dy/2)
  assign half_dx = {{(ERR_W-COORD_BITS+1){1'b0}}, delta_x[COORD_BITS-1:1]};
  assign half_dy = {{(ERR_W-COORD_BITS+1){1'b0}}, delta_y[COORD_BITS-1:1]};
  assign error_init = (delta_x > delta_y) ? $signed(half_dx) : -$signed(half_dy);

  assign half_size = thickness >> 1;

endmodule

/* rtl/tlr_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlr_step
// One brush offset per tick: pixel position, frame clip and next walk state.
// ----------------------------------------------------------------------------
module tlr_step #(
  parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
  parameter int THICK_BITS = tlr_pkg::THICK_BITS_DEF,
  parameter int ERR_W      = COORD_BITS + 3
) (
  input  logic signed [COORD_BITS-1:0]       cur_x,
  input  logic signed [COORD_BITS-1:0]       cur_y,
  input  logic signed [COORD_BITS-1:0]       goal_x,
  input  logic signed [COORD_BITS-1:0]       goal_y,
  input  logic        [COORD_BITS-1:0]       delta_x,
  input  logic        [COORD_BITS-1:0]       delta_y,
  input  logic                               step_x_neg,
  input  logic                               step_y_neg,
  input  logic signed [ERR_W-1:0]            error_term,
  input  logic        [THICK_BITS-1:0]       half_size,
  input  logic        [THICK_BITS-1:0]       offset_i,
  input  logic        [THICK_BITS-1:0]       offset_j,
  input  logic        [tlr_pkg::FRAME_W-1:0] frame_width,
  input  logic        [tlr_pkg::FRAME_W-1:0] frame_height,
  output logic        [tlr_pkg::PIX_W-1:0]   pixel_x,
  output logic        [tlr_pkg::PIX_W-1:0]   pixel_y,
  output tlr_pkg::step_ctl_t                 ctl,
  output logic signed [COORD_BITS-1:0]       cur_x_nxt,
  output logic signed [COORD_BITS-1:0]       cur_y_nxt,
  output logic signed [ERR_W-1:0]            error_nxt,
  output logic        [THICK_BITS-1:0]       offset_i_nxt,
  output logic        [THICK_BITS-1:0]       offset_j_nxt
);
  import tlr_pkg::*;

  localparam int XW = (COORD_BITS + 2 > FRAME_W + 1) ? COORD_BITS + 2 : FRAME_W + 1;

  logic [XW-1:0]         cx_e, cy_e, oi_e, oj_e, half_e;
  logic [XW-1:0]         xi, yj;
  logic [FRAME_W-1:0]    fw_lim, fh_lim;
  logic                  in_x, in_y;
  logic [THICK_BITS-1:0] side;
  logic                  at_goal;
  logic signed [ERR_W-1:0] dx_e, dy_e;
  logic                  move_x, move_y;

  assign cx_e   = {{(XW-COORD_BITS){cur_x[COORD_BITS-1]}}, cur_x};
  assign cy_e   = {{(XW-COORD_BITS){cur_y[COORD_BITS-1]}}, cur_y};
  assign oi_e   = {{(XW-THICK_BITS){1'b0}}, offset_i};
  assign oj_e   = {{(XW-THICK_BITS){1'b0}}, offset_j};
  assign half_e = {{(XW-THICK_BITS){1'b0}}, half_size};

  assign xi = cx_e + oi_e - half_e;
  assign yj = cy_e + oj_e - half_e;

  assign fw_lim = (frame_width  > PIX_LIMIT) ? PIX_LIMIT : frame_width;
  assign fh_lim = (frame_height > PIX_LIMIT) ? PIX_LIMIT : frame_height;

  assign in_x = !xi[XW-1] && (xi < {{(XW-FRAME_W){1'b0}}, fw_lim});
  assign in_y = !yj[XW-1] && (yj < {{(XW-FRAME_W){1'b0}}, fh_lim});

  assign pixel_x = xi[PIX_W-1:0];
  assign pixel_y = yj[PIX_W-1:0];

  assign side    = half_size << 1;
  assign at_goal = (cur_x == goal_x) && (cur_y == goal_y);

  assign ctl.in_frame = in_x && in_y;
  assign ctl.wrap_j   = !(offset_j < side);
  assign ctl.wrap_i   = ctl.wrap_j && !(offset_i < side);
  assign ctl.done     = ctl.wrap_i && at_goal;

  assign dx_e = $signed({{(ERR_W-COORD_BITS){1'b0}}, delta_x});
  assign dy_e = $signed({{(ERR_W-COORD_BITS){1'b0}}, delta_y});

  // Bresenham error rule, applied only when a full square is finished
  assign move_x = ctl.wrap_i && !at_goal && (error_term > -dx_e);
  assign move_y = ctl.wrap_i && !at_goal && (error_term < dy_e);

  always_comb begin
    error_nxt = error_term;
    cur_x_nxt = cur_x;
    cur_y_nxt = cur_y;
    if (move_x) begin
      error_nxt = error_nxt - dy_e;
      cur_x_nxt = step_x_neg ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
    end
    if (move_y) begin
      error_nxt = error_nxt + dx_e;
      cur_y_nxt = step_y_neg ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
    end
  end

  always_comb begin
    offset_j_nxt = ctl.wrap_j ? '0 : offset_j + THICK_BITS'(1);
    offset_i_nxt = offset_i;
    if (ctl.wrap_j) begin
      offset_i_nxt = ctl.wrap_i ? '0 : offset_i + THICK_BITS'(1);
    end
  end

endmodule

/* verif/thick_line_rasterizer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thick_line_rasterizer_core_tb
// Drives start and tick transactions into the line rasterizer with random
// idling, backpressure and one long output stall. A behavioral line walker
// predicts every pixel write, and each write is checked field by field over
// several frame sizes, the extremes among them.
// ----------------------------------------------------------------------------
module thick_line_rasterizer_core_tb;
  import tlr_pkg::*;

  localparam int CB             = COORD_BITS_DEF;
  localparam int TW             = THICK_BITS_DEF;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct {
    logic                 action;
    logic signed [CB-1:0] sx, sy, ex, ey;
    logic [COLOR_W-1:0]   color;
    logic [TW-1:0]        thick;
  } line_item_t;

  typedef struct {
    logic               we;
    logic [PIX_W-1:0]   x, y;
    logic [COLOR_W-1:0] color;
    logic               done;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t             pending_pixels[$];
    int                 errors;
    logic [FRAME_W-1:0] frame_width, frame_height;
    bit                 busy;
    logic signed [CB:0] cur_x, cur_y, goal_x, goal_y, delta_x, delta_y;
    bit                 step_x_neg, step_y_neg;
    logic signed [CB+2:0] error_term;
    logic [TW-2:0]      half_size;
    logic [TW-1:0]      offset_i, offset_j;
    logic [COLOR_W-1:0] line_color;

    function new();
      errors       = 0;
      frame_width  = FRAME_WIDTH_RST;
      frame_height = FRAME_HEIGHT_RST;
      busy         = 1'b0;
      cur_x = '0; cur_y = '0; goal_x = '0; goal_y = '0;
      delta_x = '0; delta_y = '0;
      step_x_neg = 1'b0; step_y_neg = 1'b0;
      error_term = '0;
      half_size = '0; offset_i = '0; offset_j = '0;
      line_color = '0;
    endfunction

    function void set_frame(logic [CFG_IDX_W-1:0] idx, logic [FRAME_W-1:0] val);
      if (idx == REG_FRAME_WIDTH)
        frame_width = val;
      else if (idx == REG_FRAME_HEIGHT)
        frame_height = val;
    endfunction

    // One input transaction through the line walker; returns 1 if it gives a result.
    function bit brush_step(input line_item_t it, output pixel_t px);
      int x0, y0, x1, y1, dx, dy, init;
      int xi, yj, wlim, hlim, side, err, e2;
      bit in_frame;
      px = '{default: '0};
      if (it.action == ACT_START) begin
        x0 = int'(it.sx);
        y0 = int'(it.sy);
        x1 = int'(it.ex);
        y1 = int'(it.ey);
        cur_x  = (CB+1)'(x0);
        cur_y  = (CB+1)'(y0);
        goal_x = (CB+1)'(x1);
        goal_y = (CB+1)'(y1);
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        delta_x = (CB+1)'(dx);
        delta_y = (CB+1)'(dy);
        step_x_neg = !(x0 < x1);
        step_y_neg = !(y0 < y1);
        init = (dx > dy) ? dx : -dy;
        // signed int division truncates toward zero
        error_term = (CB+3)'(init / 2);
        half_size  = (TW-1)'(it.thick >> 1);
        offset_i   = '0;
        offset_j   = '0;
        line_color = it.color;
        busy       = 1'b1;
        return 1'b0;
      end
      if (!busy)
        return 1'b0;

      xi   = int'(cur_x) + int'(offset_i) - int'(half_size);
      yj   = int'(cur_y) + int'(offset_j) - int'(half_size);
      wlim = int'((frame_width > PIX_LIMIT) ? PIX_LIMIT : frame_width);
      hlim = int'((frame_height > PIX_LIMIT) ? PIX_LIMIT : frame_height);
      in_frame = (xi >= 0) && (xi < wlim) && (yj >= 0) && (yj < hlim);
      px.we    = in_frame;
      px.x     = in_frame ? PIX_W'(xi) : '0;
      px.y     = in_frame ? PIX_W'(yj) : '0;
      px.color = in_frame ? line_color : '0;

      side = 2 * int'(half_size);
      if (int'(offset_j) < side) begin
        offset_j++;
      end else begin
        offset_j = '0;
        if (int'(offset_i) < side) begin
          offset_i++;
        end else begin
          offset_i = '0;
          if (cur_x == goal_x && cur_y == goal_y) begin
            px.done = 1'b1;
            busy    = 1'b0;
          end else begin
            // advance the line point from the error before either update
            err = int'(error_term);
            e2  = err;
            if (e2 > -int'(delta_x)) begin
              err   = err - int'(delta_y);
              cur_x = (CB+1)'(int'(cur_x) + (step_x_neg ? -1 : 1));
            end
            if (e2 < int'(delta_y)) begin
              err   = err + int'(delta_x);
              cur_y = (CB+1)'(int'(cur_y) + (step_y_neg ? -1 : 1));
            end
            error_term = (CB+3)'(err);
          end
        end
      end
      return 1'b1;
    endfunction

    function void note_item(line_item_t it);
      pixel_t px;
      if (brush_step(it, px))
        pending_pixels.push_back(px);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp_px;
      if (pending_pixels.size() == 0) begin
        $error("pixel write with none pending: x=%0d y=%0d", got.x, got.y);
        errors++;
        return;
      end
      exp_px = pending_pixels.pop_front();
      if (got.we !== exp_px.we) begin
        $error("write_enable: expected %0d, got %0d", exp_px.we, got.we);
        errors++;
      end
      if (got.x !== exp_px.x) begin
        $error("pixel_x: expected %0d, got %0d", exp_px.x, got.x);
        errors++;
      end
      if (got.y !== exp_px.y) begin
        $error("pixel_y: expected %0d, got %0d", exp_px.y, got.y);
        errors++;
      end
      if (got.color !== exp_px.color) begin
        $error("pixel_color: expected %06h, got %06h", exp_px.color, got.color);
        errors++;
      end
      if (got.done !== exp_px.done) begin
        $error("line_done: expected %0d, got %0d", exp_px.done, got.done);
        errors++;
      end
    endfunction
  endclass

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [FRAME_W-1:0]    cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic                  in_action    = 1'b0;
  logic signed [CB-1:0]  in_start_x   = '0;
  logic signed [CB-1:0]  in_start_y   = '0;
  logic signed [CB-1:0]  in_end_x     = '0;
  logic signed [CB-1:0]  in_end_y     = '0;
  logic [COLOR_W-1:0]    in_color_rgb = '0;
  logic [TW-1:0]         in_thickness = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic                  out_write_enable;
  logic [PIX_W-1:0]      out_pixel_x;
  logic [PIX_W-1:0]      out_pixel_y;
  logic [COLOR_W-1:0]    out_pixel_color;
  logic                  out_line_done;

  pixel_scoreboard sb;
  bit         tx_idle_on = 1'b1;
  bit         rx_idle_on = 1'b1;
  bit         hold_req   = 1'b0;
  int         frame_w    = 1024;
  int         frame_h    = 768;
  int         quiet_cycles = 0;
  pixel_t     mon_pixel;
  line_item_t mon_item;

  thick_line_rasterizer_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitor and watchdog: sample handshakes on the edge, before any update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        mon_pixel.we    = out_write_enable;
        mon_pixel.x     = out_pixel_x;
        mon_pixel.y     = out_pixel_y;
        mon_pixel.color = out_pixel_color;
        mon_pixel.done  = out_line_done;
        sb.check_pixel(mon_pixel);
      end
      if (in_valid && in_ready) begin
        mon_item.action = in_action;
        mon_item.sx     = in_start_x;
        mon_item.sy     = in_start_y;
        mon_item.ex     = in_end_x;
        mon_item.ey     = in_end_y;
        mon_item.color  = in_color_rgb;
        mon_item.thick  = in_thickness;
        sb.note_item(mon_item);
      end
      if (cfg_valid && cfg_ready)
        sb.set_frame(cfg_index, cfg_data);

      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= !(rx_idle_on && $urandom_range(0, 99) < 13);
    end
  end

  function automatic logic signed [CB-1:0] clamp_coord(int v);
    int hi;
    hi = (1 << (CB - 1)) - 1;
    if (v > hi)
      return CB'(hi);
    if (v < -hi - 1)
      return CB'(-hi - 1);
    return CB'(v);
  endfunction

  function automatic line_item_t random_item(logic action);
    line_item_t it;
    it.action = action;
    it.sx     = CB'($urandom);
    it.sy     = CB'($urandom);
    it.ex     = CB'($urandom);
    it.ey     = CB'($urandom);
    it.color  = COLOR_W'($urandom);
    it.thick  = TW'($urandom);
    return it;
  endfunction

  // Ticks needed to walk a whole line: one square per point.
  function automatic int line_ticks(line_item_t it);
    int dx, dy, side;
    dx = int'(it.ex) - int'(it.sx);
    dy = int'(it.ey) - int'(it.sy);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    side = 2 * (int'(it.thick) >> 1) + 1;
    return ((dx > dy ? dx : dy) + 1) * side * side;
  endfunction

  // Leave valid high after the transaction; the next call or end_phase decides.
  task automatic send_item(line_item_t it);
    while (tx_idle_on && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= it.action;
    in_start_x   <= it.sx;
    in_start_y   <= it.sy;
    in_end_x     <= it.ex;
    in_end_y     <= it.ey;
    in_color_rgb <= it.color;
    in_thickness <= it.thick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_ticks(int n);
    for (int k = 0; k < n; k++)
      send_item(random_item(ACT_TICK));
  endtask

  task automatic run_line(line_item_t st, int ticks);
    send_item(st);
    send_ticks(ticks);
  endtask

  task automatic write_frame_size(logic [FRAME_W-1:0] w, logic [FRAME_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    frame_w = int'(w);
    frame_h = int'(h);
  endtask

  // Drop valid, drain all pending writes, then let the pipeline settle.
  task automatic end_phase();
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_directed();
    line_item_t it;
    send_ticks(1);  // tick with no line running
    // square straddling the right and bottom frame edges
    it = random_item(ACT_START);
    it.sx = CB'(1023); it.sy = CB'(767); it.ex = CB'(1023); it.ey = CB'(767);
    it.color = '1; it.thick = TW'(3);
    run_line(it, line_ticks(it));
    // shallow line, odd delta_x, one-pixel brush
    it.sx = CB'(0); it.sy = CB'(0); it.ex = CB'(3); it.ey = CB'(1);
    it.color = '0; it.thick = TW'(1);
    run_line(it, line_ticks(it));
    // full-range diagonal with the widest brush, cut short by the next start
    it.sx = CB'(-2048); it.sy = CB'(2047); it.ex = CB'(2047); it.ey = CB'(-2048);
    it.color = 24'hA5A5A5; it.thick = '1;
    run_line(it, 3);
    // steep line stepping negative, initial error rounds toward zero
    it.sx = CB'(2); it.sy = CB'(0); it.ex = CB'(1); it.ey = CB'(-3);
    it.color = 24'h5A5A5A; it.thick = TW'(0);
    run_line(it, line_ticks(it));
  endtask

  task automatic run_random(int n);
    line_item_t it;
    int count, kind, lim_w, lim_h, ticks;
    count = 0;
    while (count < n) begin
      kind = $urandom_range(0, 99);
      it   = random_item(ACT_START);
      if (kind < 75) begin
        // complete line, usually near the frame, small brush
        if ($urandom_range(0, 3) != 0) begin
          lim_w = (frame_w > 2048) ? 2048 : frame_w;
          lim_h = (frame_h > 2048) ? 2048 : frame_h;
          it.sx = clamp_coord(int'($urandom_range(0, lim_w + 12)) - 6);
          it.sy = clamp_coord(int'($urandom_range(0, lim_h + 12)) - 6);
        end
        it.ex    = clamp_coord(int'(it.sx) + int'($urandom_range(0, 10)) - 5);
        it.ey    = clamp_coord(int'(it.sy) + int'($urandom_range(0, 10)) - 5);
        it.thick = TW'($urandom_range(0, 5));
        ticks    = line_ticks(it);
        run_line(it, ticks);
        count += 1 + ticks;
        if ($urandom_range(0, 4) == 0)
          send_ticks(int'($urandom_range(1, 2)));
      end else if (kind < 90) begin
        // any line, abandoned partway
        ticks = int'($urandom_range(0, 30));
        run_line(it, ticks);
        count += 1 + ticks;
      end else begin
        send_ticks(int'($urandom_range(1, 4)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    end_phase();

    write_frame_size(12'd2048, 12'd2048);
    hold_req = 1'b1;
    run_random(110);
    end_phase();

    write_frame_size(12'd1, 12'd1);
    run_random(100);
    end_phase();

    write_frame_size(12'd4095, 12'd0);
    run_random(90);
    end_phase();

    write_frame_size(12'd0, 12'd4095);
    run_random(80);
    end_phase();

    // long stretch with no idling on either side
    write_frame_size(12'd100, 12'd60);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(170);
    end_phase();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending_pixels.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
